@@ rtl/bat_pkg.sv @@
package bat_pkg;

  localparam int ADDR_W = 64;

  localparam logic [2:0] FN_ADD       = 3'd0;
  localparam logic [2:0] FN_TRAP      = 3'd1;
  localparam logic [2:0] FN_REMOVE    = 3'd2;
  localparam logic [2:0] FN_TOGGLE    = 3'd3;
  localparam logic [2:0] FN_CLR_STATS = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [7:0]  TRAP_OPCODE = 8'hCC;
  localparam logic [1:0]  NO_KIND     = 2'd3;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        sbyte;
    logic [1:0]        kind;
    logic              active;
  } entry_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

endpackage

@@ rtl/bat_ram.sv @@
module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bat_scan.sv @@
module bat_scan import bat_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             need_active,
  input  logic [ADDR_W-1:0]                key,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] used,
  output logic                             rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  entry_t                           rd_data,
  output scan_res_t                        res,
  output logic [$clog2(TABLE_DEPTH)-1:0]   hit_idx,
  output entry_t                           hit_entry
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic [UW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          issue, match;

  // one read issued per cycle, each compared in the following cycle
  assign issue = busy_r && (idx_r < used);
  assign match = pend_r && (rd_data.addr == key) && (!need_active || rd_data.active);

  assign rd_en     = issue;
  assign rd_addr   = idx_r[IW-1:0];
  assign res.done  = busy_r && (match || !issue);
  assign res.found = match;
  assign hit_idx   = pidx_r;
  assign hit_entry = rd_data;

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = issue;
    idx_nxt  = idx_r;
    pidx_nxt = pidx_r;
    if (issue) begin
      idx_nxt  = idx_r + UW'(1);
      pidx_nxt = idx_r[IW-1:0];
    end
    if (res.done) begin
      busy_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
    pidx_r <= pidx_nxt;
  end

endmodule

@@ rtl/breakpoint_address_table.sv @@
// Software breakpoint table of TABLE_DEPTH slots held in one single-port-write RAM.
// Each add, trap, remove or toggle request is searched against the used slots,
// lowest first, one RAM read per cycle, stopping early on a match; reset-statistics
// and unassigned codes go straight to the action step without a search. One request
// is worked at a time; a new one can be taken while the previous result still waits
// on out_ready. Slots fill in order and are never freed. Hit and unhandled counters
// saturate; the armed count saturates at 127.
module breakpoint_address_table import bat_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_func,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [7:0]        in_orig_byte,
  input  logic [1:0]        in_bp_type,
  input  logic              in_enable,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_matched,
  output logic [1:0]        out_matched_type,
  output logic [7:0]        out_saved_byte,
  output logic              out_patch_valid,
  output logic [7:0]        out_patch_byte,
  output logic [31:0]       out_total_hits,
  output logic [31:0]       out_unhandled_hits,
  output logic [6:0]        out_armed_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (UW > 7) ? UW : 7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_ACT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]        func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        obyte_r;
  logic [1:0]        kind_r;
  logic              en_r;

  logic          found_r;
  logic [IW-1:0] hidx_r;
  entry_t        hent_r;

  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] act_r, act_nxt;
  logic [31:0]   hit_r, hit_nxt;
  logic [31:0]   miss_r, miss_nxt;

  logic        ov_r;
  logic [1:0]  o_status_r, o_status_nxt;
  logic        o_matched_r, o_matched_nxt;
  logic [1:0]  o_mtype_r, o_mtype_nxt;
  logic [7:0]  o_sbyte_r, o_sbyte_nxt;
  logic        o_pvalid_r, o_pvalid_nxt;
  logic [7:0]  o_pbyte_r, o_pbyte_nxt;
  logic [6:0]  o_act_r;
  logic [CW-1:0] act_ext;

  logic          accept, act_go, scan_start, need_search;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr, hit_idx;
  entry_t        rd_data, wr_data, hit_entry;
  scan_res_t     scan_res;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign need_search = (in_func == FN_ADD) || (in_func == FN_TRAP) ||
                       (in_func == FN_REMOVE) || (in_func == FN_TOGGLE);
  assign scan_start  = accept && need_search;
  assign act_go      = (state_r == S_ACT) && (!ov_r || out_ready);

  bat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bat_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (scan_start),
    .need_active (func_r != FN_TOGGLE),
    .key         (addr_r),
    .used        (used_r),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res         (scan_res),
    .hit_idx     (hit_idx),
    .hit_entry   (hit_entry)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = need_search ? S_SCAN : S_ACT;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        if (act_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    o_status_nxt  = ST_OK;
    o_matched_nxt = 1'b0;
    o_mtype_nxt   = NO_KIND;
    o_sbyte_nxt   = 8'd0;
    o_pvalid_nxt  = 1'b0;
    o_pbyte_nxt   = 8'd0;
    used_nxt      = used_r;
    act_nxt       = act_r;
    hit_nxt       = hit_r;
    miss_nxt      = miss_r;
    wr_en         = 1'b0;
    wr_addr       = hidx_r;
    wr_data       = hent_r;
    unique case (func_r)
      FN_ADD: begin
        if (found_r) begin
          o_status_nxt = ST_DUP;
        end else if (used_r == UW'(TABLE_DEPTH)) begin
          o_status_nxt = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = used_r[IW-1:0];
          wr_data      = '{addr: addr_r, sbyte: obyte_r, kind: kind_r, active: 1'b1};
          used_nxt     = used_r + UW'(1);
          act_nxt      = act_r + UW'(1);
          o_pvalid_nxt = 1'b1;
          o_pbyte_nxt  = TRAP_OPCODE;
        end
      end
      FN_TRAP: begin
        if (found_r) begin
          hit_nxt       = (hit_r == COUNT_MAX) ? hit_r : hit_r + 32'd1;
          o_matched_nxt = 1'b1;
          o_mtype_nxt   = hent_r.kind;
          o_sbyte_nxt   = hent_r.sbyte;
        end else begin
          miss_nxt = (miss_r == COUNT_MAX) ? miss_r : miss_r + 32'd1;
        end
      end
      FN_REMOVE: begin
        if (!found_r) begin
          o_status_nxt = ST_MISSING;
        end else begin
          wr_en          = 1'b1;
          wr_data.active = 1'b0;
          act_nxt        = act_r - UW'(1);
          o_pvalid_nxt   = 1'b1;
          o_pbyte_nxt    = hent_r.sbyte;
        end
      end
      FN_TOGGLE: begin
        if (!found_r) begin
          o_status_nxt = ST_MISSING;
        end else if (hent_r.active != en_r) begin
          wr_en          = 1'b1;
          wr_data.active = en_r;
          act_nxt        = en_r ? act_r + UW'(1) : act_r - UW'(1);
          o_pvalid_nxt   = 1'b1;
          o_pbyte_nxt    = en_r ? TRAP_OPCODE : hent_r.sbyte;
        end
      end
      FN_CLR_STATS: begin
        hit_nxt  = 32'd0;
        miss_nxt = 32'd0;
      end
      default: begin
      end
    endcase
    if (!act_go) begin
      wr_en = 1'b0;
    end
  end

  assign act_ext = CW'(act_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      act_r   <= '0;
      hit_r   <= '0;
      miss_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (act_go) begin
        used_r <= used_nxt;
        act_r  <= act_nxt;
        hit_r  <= hit_nxt;
        miss_r <= miss_nxt;
        ov_r   <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      addr_r  <= in_address;
      obyte_r <= in_orig_byte;
      kind_r  <= in_bp_type;
      en_r    <= in_enable;
      found_r <= 1'b0;
    end
    if (state_r == S_SCAN && scan_res.done) begin
      found_r <= scan_res.found;
      hidx_r  <= hit_idx;
      hent_r  <= hit_entry;
    end
    if (act_go) begin
      o_status_r  <= o_status_nxt;
      o_matched_r <= o_matched_nxt;
      o_mtype_r   <= o_mtype_nxt;
      o_sbyte_r   <= o_sbyte_nxt;
      o_pvalid_r  <= o_pvalid_nxt;
      o_pbyte_r   <= o_pbyte_nxt;
      o_act_r     <= (act_ext > CW'(127)) ? 7'd127 : act_ext[6:0];
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = o_status_r;
  assign out_matched        = o_matched_r;
  assign out_matched_type   = o_mtype_r;
  assign out_saved_byte     = o_sbyte_r;
  assign out_patch_valid    = o_pvalid_r;
  assign out_patch_byte     = o_pbyte_r;
  assign out_total_hits     = hit_r;
  assign out_unhandled_hits = miss_r;
  assign out_armed_count    = o_act_r;

  a_act_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= used_r)
    else $error("active count exceeds used slots");

  a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_DEPTH))
    else $error("used slots exceed table depth");

  a_wr_in_act: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_ACT) && !rd_en)
    else $error("table write outside action step");

  a_act_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    act_go |=> out_valid && (state_r == S_IDLE))
    else $error("result not presented after action step");

endmodule

@@ tb/sv/tb_breakpoint_address_table.sv @@
`timescale 1ns / 1ps

module tb_breakpoint_address_table import bat_pkg::*; ();

  localparam int TABLE_DEPTH = 64;
  localparam int N_DIR = 25;
  localparam int POOL_N = 12;
  localparam int RAND_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_IN_GAP [4] = '{0, 53, 0, 16};
  localparam int PHASE_OUT_STALL [4] = '{0, 0, 53, 16};

  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ADDR_ODD = 64'h8000_0000_0000_0001;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] addr;
    logic [7:0]  obyte;
    logic [1:0]  kind;
    logic        en;
  } bp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        matched;
    logic [1:0]  mtype;
    logic [7:0]  sbyte;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [6:0]  active;
  } bp_result_t;

  typedef struct packed {
    bp_req_t    req;
    logic       typed;
    bp_result_t exp;
  } dir_row_t;

  localparam bp_result_t NO_EXP = '0;

  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{'{FN_TRAP, 64'd0, 8'h00, 2'd0, 1'b0}, 1'b1,
      '{ST_OK, 1'b0, NO_KIND, 8'h00, 1'b0, 8'h00, 32'd0, 32'd1, 7'd0}},
    '{'{FN_REMOVE, 64'd0, 8'h00, 2'd0, 1'b0}, 1'b1,
      '{ST_MISSING, 1'b0, NO_KIND, 8'h00, 1'b0, 8'h00, 32'd0, 32'd1, 7'd0}},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b1}, 1'b1,
      '{ST_MISSING, 1'b0, NO_KIND, 8'h00, 1'b0, 8'h00, 32'd0, 32'd1, 7'd0}},
    '{'{FN_ADD, ADDR_MAX, 8'hFF, 2'd3, 1'b0}, 1'b1,
      '{ST_OK, 1'b0, NO_KIND, 8'h00, 1'b1, TRAP_OPCODE, 32'd0, 32'd1, 7'd1}},
    '{'{FN_ADD, ADDR_MAX, 8'h00, 2'd0, 1'b1}, 1'b1,
      '{ST_DUP, 1'b0, NO_KIND, 8'h00, 1'b0, 8'h00, 32'd0, 32'd1, 7'd1}},
    '{'{FN_TRAP, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 2'd3, 8'hFF, 1'b0, 8'h00, 32'd1, 32'd1, 7'd1}},
    '{'{FN_ADD, 64'd0, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TRAP, 64'd0, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_REMOVE, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TRAP, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b1}, 1'b0, NO_EXP},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b1}, 1'b0, NO_EXP},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_ADD, ADDR_MAX, 8'h5A, 2'd1, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TOGGLE, ADDR_MAX, 8'h00, 2'd0, 1'b1}, 1'b0, NO_EXP},
    '{'{FN_TRAP, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_REMOVE, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TRAP, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_ADD, ADDR_ODD, 8'h80, 2'd2, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_TRAP, ADDR_ODD, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_CLR_STATS, 64'd0, 8'h00, 2'd0, 1'b0}, 1'b1,
      '{ST_OK, 1'b0, NO_KIND, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 7'd3}},
    '{'{FN_RSVD5, 64'd0, 8'hFF, 2'd3, 1'b1}, 1'b0, NO_EXP},
    '{'{FN_RSVD6, ADDR_MAX, 8'h00, 2'd0, 1'b0}, 1'b0, NO_EXP},
    '{'{FN_RSVD7, ADDR_MAX, 8'hFF, 2'd3, 1'b1}, 1'b0, NO_EXP}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [63:0] in_address;
  logic [7:0]  in_orig_byte;
  logic [1:0]  in_bp_type;
  logic        in_enable;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_matched;
  logic [1:0]  out_matched_type;
  logic [7:0]  out_saved_byte;
  logic        out_patch_valid;
  logic [7:0]  out_patch_byte;
  logic [31:0] out_total_hits;
  logic [31:0] out_unhandled_hits;
  logic [6:0]  out_armed_count;

  // table shadow
  logic [63:0] bp_addr [TABLE_DEPTH];
  logic [7:0]  bp_saved [TABLE_DEPTH];
  logic [1:0]  bp_kind [TABLE_DEPTH];
  logic        bp_active [TABLE_DEPTH];
  int unsigned bp_used = 0;
  logic [31:0] hit_cnt = '0;
  logic [31:0] miss_cnt = '0;

  bp_result_t  expected_results [$];
  logic [63:0] addr_pool [POOL_N];
  logic        cur_typed = 1'b0;
  bp_result_t  cur_exp = '0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  breakpoint_address_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_address         (in_address),
    .in_orig_byte       (in_orig_byte),
    .in_bp_type         (in_bp_type),
    .in_enable          (in_enable),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_matched        (out_matched),
    .out_matched_type   (out_matched_type),
    .out_saved_byte     (out_saved_byte),
    .out_patch_valid    (out_patch_valid),
    .out_patch_byte     (out_patch_byte),
    .out_total_hits     (out_total_hits),
    .out_unhandled_hits (out_unhandled_hits),
    .out_armed_count    (out_armed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int lookup_slot(logic [63:0] a, bit need_active);
    for (int i = 0; i < int'(bp_used); i++) begin
      if (bp_addr[i] == a && (!need_active || bp_active[i])) return i;
    end
    return -1;
  endfunction

  function automatic bp_result_t predict_bp_result(bp_req_t r);
    bp_result_t  res;
    int          slot;
    int unsigned n_act;
    res = '0;
    res.status = ST_OK;
    res.mtype = NO_KIND;
    case (r.func)
      FN_ADD: begin
        if (lookup_slot(r.addr, 1'b1) >= 0) begin
          res.status = ST_DUP;
        end else if (bp_used >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          bp_addr[bp_used] = r.addr;
          bp_saved[bp_used] = r.obyte;
          bp_kind[bp_used] = r.kind;
          bp_active[bp_used] = 1'b1;
          bp_used++;
          res.pvalid = 1'b1;
          res.pbyte = TRAP_OPCODE;
        end
      end
      FN_TRAP: begin
        slot = lookup_slot(r.addr, 1'b1);
        if (slot < 0) begin
          if (miss_cnt != COUNT_MAX) miss_cnt++;
        end else begin
          if (hit_cnt != COUNT_MAX) hit_cnt++;
          res.matched = 1'b1;
          res.mtype = bp_kind[slot];
          res.sbyte = bp_saved[slot];
        end
      end
      FN_REMOVE: begin
        slot = lookup_slot(r.addr, 1'b1);
        if (slot < 0) begin
          res.status = ST_MISSING;
        end else begin
          bp_active[slot] = 1'b0;
          res.pvalid = 1'b1;
          res.pbyte = bp_saved[slot];
        end
      end
      FN_TOGGLE: begin
        slot = lookup_slot(r.addr, 1'b0);
        if (slot < 0) begin
          res.status = ST_MISSING;
        end else if (bp_active[slot] != r.en) begin
          bp_active[slot] = r.en;
          res.pvalid = 1'b1;
          res.pbyte = r.en ? TRAP_OPCODE : bp_saved[slot];
        end
      end
      FN_CLR_STATS: begin
        hit_cnt = '0;
        miss_cnt = '0;
      end
      default: ;
    endcase
    n_act = 0;
    for (int i = 0; i < int'(bp_used); i++) begin
      if (bp_active[i]) n_act++;
    end
    res.hits = hit_cnt;
    res.misses = miss_cnt;
    res.active = 7'((n_act > 127) ? 127 : n_act);
    return res;
  endfunction

  function automatic bp_req_t random_request();
    bp_req_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) r.func = FN_ADD;
    else if (pick < 55) r.func = FN_TRAP;
    else if (pick < 70) r.func = FN_REMOVE;
    else if (pick < 88) r.func = FN_TOGGLE;
    else if (pick < 93) r.func = FN_CLR_STATS;
    else r.func = 3'($urandom_range(FN_RSVD7, FN_RSVD5));
    if ($urandom_range(99) < ((r.func == FN_ADD) ? 45 : 75)) begin
      r.addr = addr_pool[$urandom_range(POOL_N - 1)];
    end else begin
      r.addr = {$urandom, $urandom};
    end
    r.obyte = 8'($urandom_range(255));
    r.kind = 2'($urandom_range(3));
    r.en = 1'($urandom_range(1));
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(bp_req_t r, logic typed, bp_result_t e);
    int unsigned seen;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_address <= r.addr;
    in_orig_byte <= r.obyte;
    in_bp_type <= r.kind;
    in_enable <= r.en;
    cur_typed <= typed;
    cur_exp <= e;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    bp_result_t got;
    bp_result_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        n_results++;
        got = '{out_status, out_matched, out_matched_type, out_saved_byte,
                out_patch_valid, out_patch_byte, out_total_hits,
                out_unhandled_hits, out_armed_count};
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("result %0d arrived with no request pending: %p", n_results, got);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.status !== got.status || want.matched !== got.matched ||
              want.mtype !== got.mtype || want.sbyte !== got.sbyte ||
              want.pvalid !== got.pvalid || want.pbyte !== got.pbyte ||
              want.hits !== got.hits || want.misses !== got.misses ||
              want.active !== got.active) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d mismatch (exp/act): status %0d/%0d matched %0b/%0b",
                       n_results, want.status, got.status, want.matched, got.matched);
              $display("  type %0d/%0d saved %h/%h patch %0b/%0b byte %h/%h",
                       want.mtype, got.mtype, want.sbyte, got.sbyte,
                       want.pvalid, got.pvalid, want.pbyte, got.pbyte);
              $display("  hits %0d/%0d unhandled %0d/%0d active %0d/%0d",
                       want.hits, got.hits, want.misses, got.misses,
                       want.active, got.active);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        want = predict_bp_result('{in_func, in_address, in_orig_byte, in_bp_type,
                                   in_enable});
        if (cur_typed) want = cur_exp;
        expected_results.push_back(want);
        n_accepted++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bp_req_t     req;
    int unsigned n_sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_ADD;
    in_address = '0;
    in_orig_byte = '0;
    in_bp_type = '0;
    in_enable = 1'b0;
    addr_pool[0] = 64'd0;
    addr_pool[1] = ADDR_MAX;
    addr_pool[2] = 64'h8000_0000_0000_0000;
    addr_pool[3] = 64'd1;
    for (int i = 4; i < POOL_N; i++) addr_pool[i] = {$urandom, $urandom};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].exp);
    end

    for (int p = 0; p < 4; p++) begin
      in_gap_pct = PHASE_IN_GAP[p];
      out_stall_pct = PHASE_OUT_STALL[p];
      n_sent = 0;
      while (n_sent < RAND_PER_PHASE) begin
        // long output back-pressure while requests keep coming
        if (p == 0 && n_sent == 40) hold_reqs++;
        req = random_request();
        send_request(req, 1'b0, NO_EXP);
        if (req.func <= FN_CLR_STATS) n_sent++;
      end
      in_valid <= 1'b0;
      do @(negedge clk); while (expected_results.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
